// ----- rtl/fmmq_pkg.sv -----
// ============================================================================
// fmmq_pkg
// Shared types, codes and constants of the min/max query FIFO.
// ============================================================================
`default_nettype none

package fmmq_pkg;

  localparam int unsigned FMMQ_DEPTH = 32;

  typedef logic signed [7:0] val_t;

  localparam val_t EMPTY_MARK = 8'sd45;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [1:0] ST_OVERFLOW  = 2'd2;

  typedef struct packed {
    logic apply;
    logic scan;
    logic load;
  } fmmq_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } fmmq_sts_t;

endpackage

`default_nettype wire

// ----- rtl/fmmq_if.sv -----
// ============================================================================
// fmmq_if
// Request and response channels of the min/max query FIFO.
// ============================================================================
`default_nettype none

interface fmmq_req_if
  import fmmq_pkg::*;
();
  logic valid;
  logic ready;
  logic op;
  val_t push_value;

  modport source (output valid, output op, output push_value, input ready);
  modport sink   (input valid, input op, input push_value, output ready);
endinterface

interface fmmq_rsp_if
  import fmmq_pkg::*;
();
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [5:0] entry_count;
  logic       is_empty;
  val_t       min_value;
  val_t       max_value;

  modport source (output valid, output status, output entry_count, output is_empty,
                  output min_value, output max_value, input ready);
  modport sink   (input valid, input status, input entry_count, input is_empty,
                  input min_value, input max_value, output ready);
endinterface

`default_nettype wire

// ----- rtl/fmmq_ctrl.sv -----
// ============================================================================
// fmmq_ctrl
// Controller that sequences request intake, the min/max scan and the result load.
// ============================================================================
`default_nettype none

module fmmq_ctrl
  import fmmq_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire fmmq_sts_t sts_i,
  output fmmq_cmd_t      cmd_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StScan = 1'b1;

  logic state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.apply = 1'b1;
          state_d     = StScan;
        end
      end
      StScan: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done && sts_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/fmmq_dp.sv -----
// ============================================================================
// fmmq_dp
// Datapath: ring buffer storage, pointers, min/max scan and result register.
// ============================================================================
`default_nettype none

module fmmq_dp
  import fmmq_pkg::*;
#(
  parameter int unsigned DEPTH = FMMQ_DEPTH
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire fmmq_cmd_t cmd_i,
  output fmmq_sts_t      sts_o,
  input  wire logic      op_i,
  input  wire val_t      push_value_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output logic [1:0]     status_o,
  output logic [5:0]     entry_count_o,
  output logic           is_empty_o,
  output val_t           min_value_o,
  output val_t           max_value_o
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  val_t mem [DEPTH];

  logic [IW-1:0] head_q, tail_q, scan_idx_q;
  logic [CW-1:0] cnt_q, iss_cnt_q;
  logic [1:0]    st_q;
  logic          rd_vld_q, first_q;
  val_t          rd_data_q, min_q, max_q;
  logic          out_valid_q;

  logic          do_push, do_pop, issue;
  logic [IW-1:0] head_d, tail_d;
  logic [CW-1:0] cnt_d;
  logic [1:0]    st_d;

  function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] i);
    return (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  always_comb begin
    do_push = (op_i == OP_PUSH) && (cnt_q != FULL_CNT);
    do_pop  = (op_i == OP_POP) && (cnt_q != '0);
    head_d  = do_pop ? next_idx(head_q) : head_q;
    tail_d  = do_push ? next_idx(tail_q) : tail_q;
    if (do_push) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end else begin
      cnt_d = cnt_q;
    end
    if (op_i == OP_PUSH) begin
      st_d = do_push ? ST_DONE : ST_OVERFLOW;
    end else begin
      st_d = do_pop ? ST_DONE : ST_UNDERFLOW;
    end
  end

  assign issue           = cmd_i.scan && (iss_cnt_q != cnt_q);
  assign sts_o.scan_done = (iss_cnt_q == cnt_q) && !rd_vld_q;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.apply && do_push) begin
      mem[tail_q] <= push_value_i;
    end
    rd_data_q <= mem[scan_idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      cnt_q       <= '0;
      scan_idx_q  <= '0;
      iss_cnt_q   <= '0;
      rd_vld_q    <= 1'b0;
      first_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      rd_vld_q <= issue;
      if (cmd_i.apply) begin
        head_q     <= head_d;
        tail_q     <= tail_d;
        cnt_q      <= cnt_d;
        scan_idx_q <= head_d;
        iss_cnt_q  <= '0;
        first_q    <= 1'b1;
      end else if (issue) begin
        scan_idx_q <= next_idx(scan_idx_q);
        iss_cnt_q  <= iss_cnt_q + 1'b1;
      end
      if (rd_vld_q) begin
        first_q <= 1'b0;
      end
      if (cmd_i.load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.apply) begin
      st_q <= st_d;
    end
    if (rd_vld_q) begin
      if (first_q || (rd_data_q < min_q)) begin
        min_q <= rd_data_q;
      end
      if (first_q || (rd_data_q > max_q)) begin
        max_q <= rd_data_q;
      end
    end
    if (cmd_i.load) begin
      status_o      <= st_q;
      entry_count_o <= 6'(cnt_q);
      is_empty_o    <= (cnt_q == '0);
      min_value_o   <= (cnt_q == '0) ? EMPTY_MARK : min_q;
      max_value_o   <= (cnt_q == '0) ? EMPTY_MARK : max_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ----- rtl/fifo_with_min_max_query.sv -----
// ============================================================================
// fifo_with_min_max_query
// FIFO of signed 8-bit values that reports the minimum and maximum it holds.
// ============================================================================
// Each request transfer on req_i is a push of push_value at the tail or a pop
// from the head. Each request produces exactly one response transfer on rsp_o
// carrying a status, the entry count, an empty flag and the minimum and
// maximum over the held entries, which read as 45 when the FIFO is empty.
// A pop on an empty FIFO reports underflow; a push to a full FIFO is dropped
// and reports overflow.
// After a request is accepted, the held entries are rescanned one per cycle
// through the single read port of the storage array. When the scan is done
// and the output register is free, the response is loaded into it and the
// next request can then be accepted.
// The response is held in an output register, so a new request is accepted
// while an earlier response still waits; if the receiver stalls, the next
// scan finishes and then waits until the output register is free.
// Reset empties the FIFO and drops any pending response; storage contents are
// not cleared, since only entries written by a push are ever read.
// ============================================================================
`default_nettype none

module fifo_with_min_max_query
  import fmmq_pkg::*;
#(
  parameter int unsigned DEPTH = FMMQ_DEPTH
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  fmmq_req_if.sink  req_i,
  fmmq_rsp_if.source rsp_o
);

  fmmq_cmd_t cmd;
  fmmq_sts_t sts;

  fmmq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fmmq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .op_i          (req_i.op),
    .push_value_i  (req_i.push_value),
    .out_valid_o   (rsp_o.valid),
    .out_ready_i   (rsp_o.ready),
    .status_o      (rsp_o.status),
    .entry_count_o (rsp_o.entry_count),
    .is_empty_o    (rsp_o.is_empty),
    .min_value_o   (rsp_o.min_value),
    .max_value_o   (rsp_o.max_value)
  );

endmodule

`default_nettype wire
